### rtl/aesbc_pkg.sv
// ----------------------------------------------------------------------------
// aesbc_pkg
// Shared types, lookup tables and round functions for the AES block cipher.
// ----------------------------------------------------------------------------
package aesbc_pkg;

  localparam int unsigned BlockW  = 128;
  localparam int unsigned WordW   = 32;
  localparam int unsigned RowAw   = 4;
  localparam int unsigned WordIdxW = 6;

  localparam logic [1:0] ModeKey128 = 2'd0;
  localparam logic [1:0] ModeKey192 = 2'd1;
  localparam logic [1:0] ModeKey256 = 2'd2;
  localparam logic [1:0] ModeSpare  = 2'd3;

  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegKey0   = 3'd1;
  localparam logic [2:0] RegKey1   = 3'd2;
  localparam logic [2:0] RegKey2   = 3'd3;
  localparam logic [2:0] RegKey3   = 3'd4;

  localparam logic [7:0] RconInit = 8'h01;
  localparam logic [7:0] GfPoly   = 8'h1b;

  // Controller to datapath
  typedef struct packed {
    logic             ks_clear;
    logic             ks_step;
    logic             ld_block;
    logic             add_first;
    logic             round_en;
    logic             last_round;
    logic [RowAw-1:0] rd_row;
    logic             out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ks_last;
    logic func;
  } sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [3:0] nk_of(input logic [1:0] mode);
    case (mode)
      ModeKey128: nk_of = 4'd4;
      ModeKey192: nk_of = 4'd6;
      default:    nk_of = 4'd8;
    endcase
  endfunction

  function automatic logic [3:0] nr_of(input logic [1:0] mode);
    nr_of = nk_of(mode) + 4'd6;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int unsigned i);
    get_byte = s[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [BlockW-1:0] sbox_state(input logic [BlockW-1:0] s, input logic inv);
    logic [BlockW-1:0] t;
    t = '0;
    for (int unsigned i = 0; i < 16; i++) begin
      t[BlockW-1-8*i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
    end
    sbox_state = t;
  endfunction

  function automatic logic [BlockW-1:0] shift_rows(input logic [BlockW-1:0] s, input logic inv);
    logic [BlockW-1:0] t;
    int unsigned r, c, src;
    t = '0;
    for (int unsigned i = 0; i < 16; i++) begin
      r = i % 4;
      c = i / 4;
      src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
      t[BlockW-1-8*i -: 8] = get_byte(s, r + 4 * src);
    end
    shift_rows = t;
  endfunction

  function automatic logic [WordW-1:0] mix_word(input logic [WordW-1:0] w);
    logic [7:0] b0, b1, b2, b3;
    b0 = w[31:24]; b1 = w[23:16]; b2 = w[15:8]; b3 = w[7:0];
    mix_word = {xtime(b0) ^ xtime(b1) ^ b1 ^ b2 ^ b3,
                b0 ^ xtime(b1) ^ xtime(b2) ^ b2 ^ b3,
                b0 ^ b1 ^ xtime(b2) ^ xtime(b3) ^ b3,
                xtime(b0) ^ b0 ^ b1 ^ b2 ^ xtime(b3)};
  endfunction

  function automatic logic [WordW-1:0] inv_mix_word(input logic [WordW-1:0] w);
    logic [7:0] b [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int unsigned k = 0; k < 4; k++) begin
      b[k] = w[31-8*k -: 8];
      x2 = xtime(b[k]);
      x4 = xtime(x2);
      x8 = xtime(x4);
      m9[k]  = x8 ^ b[k];
      m11[k] = x8 ^ x2 ^ b[k];
      m13[k] = x8 ^ x4 ^ b[k];
      m14[k] = x8 ^ x4 ^ x2;
    end
    inv_mix_word = {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
                    m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
                    m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
                    m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
  endfunction

  function automatic logic [BlockW-1:0] mix_state(input logic [BlockW-1:0] s, input logic inv);
    logic [BlockW-1:0] t;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      t[BlockW-1-32*c -: 32] = inv ? inv_mix_word(s[BlockW-1-32*c -: 32])
                                   : mix_word(s[BlockW-1-32*c -: 32]);
    end
    mix_state = t;
  endfunction

endpackage

### rtl/aesbc_intf.sv
// ----------------------------------------------------------------------------
// aesbc_intf
// Valid/ready channels for cipher requests and cipher results.
// ----------------------------------------------------------------------------
interface aesbc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] block_upper;
  logic [63:0] block_lower;

  modport source (output valid, output func, output block_upper, output block_lower,
                  input ready);
  modport sink (input valid, input func, input block_upper, input block_lower,
                output ready);
endinterface

interface aesbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_upper;
  logic [63:0] result_lower;

  modport source (output valid, output result_upper, output result_lower, input ready);
  modport sink (input valid, input result_upper, input result_lower, output ready);
endinterface

### rtl/aes_block_cipher.sv
// ----------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 encrypt and decrypt of one 128-bit block per transaction.
// ----------------------------------------------------------------------------
// Write the key length and key bytes through the APB port, then send blocks
// with func 0 to encrypt or 1 to decrypt. One block is in work at a time. A
// block passes a registered round-key read, the first key addition and Nr
// rounds (Nr = 10, 12 or 14) on the single round unit, which does one round
// per cycle, then goes into the result register once that register is free;
// the controller returns to idle before it takes a new block. After reset or
// any register write the first block also waits while the key schedule is
// rebuilt, one word per cycle: 4*(Nr+1) words (44, 52 or 60). The result
// register frees the round unit, so the next block is taken while a result
// still waits downstream. Key length code 3 acts as a 256-bit key.
// Decryption uses the equivalent inverse cipher with its own round-key memory.
module aes_block_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  aesbc_in_if.sink           in_i,
  aesbc_out_if.source        out_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [5:0]         paddr_i,
  input  logic [63:0]        pwdata_i,
  output logic [63:0]        prdata_o,
  output logic               pready_o
);

  logic [1:0]       mode_q;
  logic [3:0][63:0] key_q;
  logic             stale_q;
  logic             stale_clr;
  logic             wr_en;
  logic [2:0]       reg_idx;
  aesbc_pkg::cmd_t  cmd;
  aesbc_pkg::sts_t  sts;
  logic [127:0]     result;

  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[5:3];
  assign wr_en    = psel_i & penable_i & pwrite_i;

  // Register file; any valid write marks the schedule stale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      key_q   <= '0;
      stale_q <= 1'b1;
    end else begin
      if (stale_clr) begin
        stale_q <= 1'b0;
      end
      if (wr_en) begin
        case (reg_idx)
          aesbc_pkg::RegMode: begin
            mode_q  <= pwdata_i[1:0];
            stale_q <= 1'b1;
          end
          aesbc_pkg::RegKey0: begin
            key_q[0] <= pwdata_i;
            stale_q  <= 1'b1;
          end
          aesbc_pkg::RegKey1: begin
            key_q[1] <= pwdata_i;
            stale_q  <= 1'b1;
          end
          aesbc_pkg::RegKey2: begin
            key_q[2] <= pwdata_i;
            stale_q  <= 1'b1;
          end
          aesbc_pkg::RegKey3: begin
            key_q[3] <= pwdata_i;
            stale_q  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      aesbc_pkg::RegMode: prdata_o = {62'd0, mode_q};
      aesbc_pkg::RegKey0: prdata_o = key_q[0];
      aesbc_pkg::RegKey1: prdata_o = key_q[1];
      aesbc_pkg::RegKey2: prdata_o = key_q[2];
      aesbc_pkg::RegKey3: prdata_o = key_q[3];
      default:            prdata_o = '0;
    endcase
  end

  aesbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .stale_i     (stale_q),
    .stale_clr_o (stale_clr),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  aesbc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .mode_i   (mode_q),
    .key_i    (key_q),
    .func_i   (in_i.func),
    .block_i  ({in_i.block_upper, in_i.block_lower}),
    .result_o (result)
  );

  assign out_o.result_upper = result[127:64];
  assign out_o.result_lower = result[63:0];

endmodule

### rtl/aesbc_datapath.sv
// ----------------------------------------------------------------------------
// aesbc_datapath
// Key expansion, round-key memories, round logic and result register.
// ----------------------------------------------------------------------------
module aesbc_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aesbc_pkg::cmd_t                 cmd_i,
  output aesbc_pkg::sts_t                 sts_o,
  input  logic [1:0]                      mode_i,
  input  logic [3:0][63:0]                key_i,
  input  logic                            func_i,
  input  logic [aesbc_pkg::BlockW-1:0]    block_i,
  output logic [aesbc_pkg::BlockW-1:0]    result_o
);

  localparam int unsigned Rows = 2 ** aesbc_pkg::RowAw;

  logic [7:0][aesbc_pkg::WordW-1:0]      win_q;
  logic [aesbc_pkg::WordIdxW-1:0]        idx_q;
  logic [2:0]                            modnk_q;
  logic [7:0]                            rc_q;
  logic [aesbc_pkg::BlockW-1:0]          enc_mem [Rows];
  logic [aesbc_pkg::BlockW-1:0]          dec_mem [Rows];
  logic [aesbc_pkg::BlockW-1:0]          enc_rk_q, dec_rk_q;
  logic [aesbc_pkg::BlockW-1:0]          state_q, result_q;
  logic                                  func_q;

  logic [3:0]                            nk, nr;
  logic [aesbc_pkg::WordW-1:0]           key_word, old_word, tmp, rot, new_word;
  logic [aesbc_pkg::BlockW-1:0]          row_data, row_dec;
  logic [aesbc_pkg::RowAw-1:0]           wr_row;
  logic [aesbc_pkg::BlockW-1:0]          rk, sb, sr, mc, rnd_out;

  assign nk = aesbc_pkg::nk_of(mode_i);
  assign nr = aesbc_pkg::nr_of(mode_i);

  // Next schedule word
  always_comb begin
    key_word = idx_q[0] ? key_i[idx_q[2:1]][31:0] : key_i[idx_q[2:1]][63:32];
    case (mode_i)
      aesbc_pkg::ModeKey128: old_word = win_q[3];
      aesbc_pkg::ModeKey192: old_word = win_q[5];
      default:               old_word = win_q[7];
    endcase
    rot = {win_q[0][23:0], win_q[0][31:24]};
    tmp = win_q[0];
    if (modnk_q == 3'd0) begin
      tmp = {aesbc_pkg::SBOX[rot[31:24]], aesbc_pkg::SBOX[rot[23:16]],
             aesbc_pkg::SBOX[rot[15:8]], aesbc_pkg::SBOX[rot[7:0]]} ^ {rc_q, 24'h0};
    end else if (nk == 4'd8 && idx_q[2:0] == 3'd4) begin
      tmp = {aesbc_pkg::SBOX[win_q[0][31:24]], aesbc_pkg::SBOX[win_q[0][23:16]],
             aesbc_pkg::SBOX[win_q[0][15:8]], aesbc_pkg::SBOX[win_q[0][7:0]]};
    end
    new_word = ({2'b00, idx_q} < {4'd0, nk}) ? key_word : (old_word ^ tmp);
    row_data = {win_q[2], win_q[1], win_q[0], new_word};
    wr_row   = idx_q[aesbc_pkg::WordIdxW-1:2];
    row_dec  = row_data;
    if (wr_row != '0 && wr_row < nr) begin
      row_dec = aesbc_pkg::mix_state(row_data, 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      modnk_q <= '0;
      rc_q    <= aesbc_pkg::RconInit;
    end else if (cmd_i.ks_clear) begin
      idx_q   <= '0;
      modnk_q <= '0;
      rc_q    <= aesbc_pkg::RconInit;
    end else if (cmd_i.ks_step) begin
      idx_q   <= idx_q + aesbc_pkg::WordIdxW'(1);
      modnk_q <= ({1'b0, modnk_q} == nk - 4'd1) ? 3'd0 : modnk_q + 3'd1;
      if (modnk_q == 3'd0 && {2'b00, idx_q} >= {4'd0, nk}) begin
        rc_q <= aesbc_pkg::xtime(rc_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ks_step) begin
      win_q <= {win_q[6:0], new_word};
      if (idx_q[1:0] == 2'b11) begin
        enc_mem[wr_row] <= row_data;
        dec_mem[wr_row] <= row_dec;
      end
    end
    enc_rk_q <= enc_mem[cmd_i.rd_row];
    dec_rk_q <= dec_mem[cmd_i.rd_row];
  end

  // One cipher round
  always_comb begin
    rk = func_q ? dec_rk_q : enc_rk_q;
    sb = aesbc_pkg::sbox_state(state_q, func_q);
    sr = aesbc_pkg::shift_rows(sb, func_q);
    mc = aesbc_pkg::mix_state(sr, func_q);
    rnd_out = (cmd_i.last_round ? sr : mc) ^ rk;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_block) begin
      state_q <= block_i;
      func_q  <= func_i;
    end else if (cmd_i.add_first) begin
      state_q <= state_q ^ rk;
    end else if (cmd_i.round_en) begin
      state_q <= rnd_out;
    end
    if (cmd_i.out_load) begin
      result_q <= state_q;
    end
  end

  assign sts_o.ks_last = (idx_q == {nr, 2'b11});
  assign sts_o.func    = func_q;
  assign result_o      = result_q;

endmodule

### rtl/aesbc_ctrl.sv
// ----------------------------------------------------------------------------
// aesbc_ctrl
// Sequencer for key expansion, cipher rounds and result hand-off.
// ----------------------------------------------------------------------------
module aesbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      mode_i,
  input  logic            stale_i,
  output logic            stale_clr_o,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output aesbc_pkg::cmd_t cmd_o,
  input  aesbc_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    StIdle,
    StBuild,
    StIssue,
    StAdd0,
    StRound,
    StDone
  } state_e;

  state_e                      state_q, state_d;
  logic [aesbc_pkg::RowAw-1:0] rnd_q, rnd_d, nr, issue;
  logic                        out_valid_q, out_valid_d;

  assign nr = aesbc_pkg::nr_of(mode_i);

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    cmd_o       = '0;
    stale_clr_o = 1'b0;
    issue       = '0;
    case (state_q)
      StIdle: begin
        cmd_o.ks_clear = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_block = 1'b1;
          state_d = stale_i ? StBuild : StIssue;
        end
      end
      StBuild: begin
        cmd_o.ks_step = 1'b1;
        if (sts_i.ks_last) begin
          stale_clr_o = 1'b1;
          state_d = StIssue;
        end
      end
      StIssue: begin
        issue = '0;
        rnd_d = '0;
        state_d = StAdd0;
      end
      StAdd0: begin
        cmd_o.add_first = 1'b1;
        issue = 4'd1;
        rnd_d = 4'd1;
        state_d = StRound;
      end
      StRound: begin
        cmd_o.round_en   = 1'b1;
        cmd_o.last_round = (rnd_q == nr);
        issue = rnd_q + 4'd1;
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == nr) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    // Decryption walks the schedule from the last round key down
    cmd_o.rd_row = sts_i.func ? nr - issue : issue;
    out_valid_d  = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

### test/aes_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_tb
// Self-checking bench: predicts every cipher result in software AES
// (FIPS-197, equivalent inverse cipher), drives blocks under random idling
// and back-pressure, and rewrites the key registers between phases.
// ----------------------------------------------------------------------------

// Expected result blocks, kept in acceptance order.
class cipher_scoreboard;
  logic [63:0] exp_hi[$];
  logic [63:0] exp_lo[$];
  int unsigned errors;
  int unsigned checked;

  function void note_block(logic [63:0] hi, logic [63:0] lo);
    exp_hi.push_back(hi);
    exp_lo.push_back(lo);
  endfunction

  function void check_result(logic [63:0] hi, logic [63:0] lo);
    logic [63:0] eh, el;
    if (exp_hi.size() == 0) begin
      $error("result with nothing expected: %h %h", hi, lo);
      errors++;
      return;
    end
    eh = exp_hi.pop_front();
    el = exp_lo.pop_front();
    checked++;
    if (hi !== eh) begin
      $error("result_upper expected %h actual %h", eh, hi);
      errors++;
    end
    if (lo !== el) begin
      $error("result_lower expected %h actual %h", el, lo);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return exp_hi.size();
  endfunction
endclass

module aes_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  aesbc_in_if  req_if();
  aesbc_out_if rsp_if();

  aes_block_cipher uut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(req_if.sink), .out_o(rsp_if.source),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  always #5 clk = ~clk;

  cipher_scoreboard sb = new();

  // Predictor copy of the configuration and the expanded schedules.
  logic [1:0]  cfg_mode;
  logic [63:0] cfg_key[4];
  logic [31:0] enc_rk[60];
  logic [31:0] dec_rk[60];
  bit          rk_stale;
  logic [7:0]  inv_tab[256];

  // Stimulus control.
  int unsigned cycle_cnt;
  bit          no_idle;      // drop random idling on both sides
  bit          sink_hold;    // hold off the receiver for a long stretch
  int unsigned encs, decs;

  initial begin
    req_if.valid = 1'b0;
    req_if.func = 1'b0;
    req_if.block_upper = '0;
    req_if.block_lower = '0;
    rsp_if.ready = 1'b0;
    for (int i = 0; i < 256; i++) inv_tab[aesbc_pkg::SBOX[i]] = i[7:0];
  end

  // GF(2^8) arithmetic written out here, independent of the package helpers.
  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, int unsigned b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  function automatic logic [31:0] col_unmix(logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    {a0, a1, a2, a3} = w;
    return {gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9),
            gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13),
            gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11),
            gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14)};
  endfunction

  function automatic logic [31:0] col_mix(logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    {a0, a1, a2, a3} = w;
    return {gf_mul(a0, 2) ^ gf_mul(a1, 3) ^ a2 ^ a3,
            a0 ^ gf_mul(a1, 2) ^ gf_mul(a2, 3) ^ a3,
            a0 ^ a1 ^ gf_mul(a2, 2) ^ gf_mul(a3, 3),
            gf_mul(a0, 3) ^ a1 ^ a2 ^ gf_mul(a3, 2)};
  endfunction

  function automatic logic [31:0] word_sub(logic [31:0] w);
    return {aesbc_pkg::SBOX[w[31:24]], aesbc_pkg::SBOX[w[23:16]],
            aesbc_pkg::SBOX[w[15:8]], aesbc_pkg::SBOX[w[7:0]]};
  endfunction

  function automatic int unsigned key_words();
    return (cfg_mode == aesbc_pkg::ModeKey128) ? 4 :
           (cfg_mode == aesbc_pkg::ModeKey192) ? 6 : 8;
  endfunction

  // Expand the key into forward and equivalent-inverse round keys.
  task automatic expand_keys();
    int unsigned nk, nr, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = key_words();
    nr = nk + 6;
    total = 4 * (nr + 1);
    rc = 8'h01;
    for (int unsigned i = 0; i < nk; i++)
      enc_rk[i] = i[0] ? cfg_key[i/2][31:0] : cfg_key[i/2][63:32];
    for (int unsigned i = nk; i < total; i++) begin
      t = enc_rk[i-1];
      if (i % nk == 0) begin
        t = word_sub({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk == 8 && i % 8 == 4) begin
        t = word_sub(t);
      end
      enc_rk[i] = enc_rk[i-nk] ^ t;
    end
    for (int unsigned i = 0; i < total; i++)
      dec_rk[i] = (i >= 4 && i < 4 * nr) ? col_unmix(enc_rk[i]) : enc_rk[i];
    rk_stale = 1'b0;
  endtask

  // State as 16 bytes in column order, byte 0 first.
  typedef logic [7:0] st_t[16];

  function automatic st_t add_rk(st_t s, bit use_dec, int unsigned rnd);
    logic [31:0] w;
    for (int unsigned c = 0; c < 4; c++) begin
      w = use_dec ? dec_rk[4*rnd+c] : enc_rk[4*rnd+c];
      for (int unsigned r = 0; r < 4; r++) s[4*c+r] ^= w[31-8*r -: 8];
    end
    return s;
  endfunction

  function automatic st_t rotate_rows(st_t s, bit inv);
    st_t t;
    int unsigned r, c, src;
    for (int unsigned i = 0; i < 16; i++) begin
      r = i % 4;
      c = i / 4;
      src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
      t[i] = s[r + 4*src];
    end
    return t;
  endfunction

  function automatic st_t subst(st_t s, bit inv);
    for (int i = 0; i < 16; i++) s[i] = inv ? inv_tab[s[i]] : aesbc_pkg::SBOX[s[i]];
    return s;
  endfunction

  function automatic st_t mix_all(st_t s, bit inv);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = {s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]};
      w = inv ? col_unmix(w) : col_mix(w);
      {s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]} = w;
    end
    return s;
  endfunction

  // Compute the expected output block for one request.
  task automatic predict_block(input logic dir, input logic [63:0] hi, input logic [63:0] lo,
                               output logic [63:0] ohi, output logic [63:0] olo);
    st_t s;
    int unsigned nr;
    if (rk_stale) expand_keys();
    nr = key_words() + 6;
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63-8*i -: 8];
      s[8+i] = lo[63-8*i -: 8];
    end
    if (!dir) begin
      s = add_rk(s, 0, 0);
      for (int unsigned r = 1; r < nr; r++)
        s = add_rk(mix_all(rotate_rows(subst(s, 0), 0), 0), 0, r);
      s = add_rk(rotate_rows(subst(s, 0), 0), 0, nr);
    end else begin
      s = add_rk(s, 1, nr);
      for (int unsigned r = nr - 1; r > 0; r--)
        s = add_rk(mix_all(rotate_rows(subst(s, 1), 1), 1), 1, r);
      s = add_rk(rotate_rows(subst(s, 1), 1), 1, 0);
    end
    for (int i = 0; i < 8; i++) begin
      ohi[63-8*i -: 8] = s[i];
      olo[63-8*i -: 8] = s[8+i];
    end
  endtask

  // APB write: setup cycle, then access cycle; the register is written at the end of the access cycle.
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == aesbc_pkg::RegMode) cfg_mode = val[1:0];
    else cfg_key[idx - aesbc_pkg::RegKey0] = val;
    rk_stale = 1'b1;
  endtask

  task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    reg_write(aesbc_pkg::RegMode, {62'd0, mode});
    reg_write(aesbc_pkg::RegKey0, k0);
    reg_write(aesbc_pkg::RegKey1, k1);
    reg_write(aesbc_pkg::RegKey2, k2);
    reg_write(aesbc_pkg::RegKey3, k3);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one block, hold it until accepted, and note its expected result.
  // Valid drops only while idling before the next block or in drain.
  task automatic send_block(input logic dir, input logic [63:0] hi, input logic [63:0] lo);
    logic [63:0] eh, el;
    while (!no_idle && $urandom_range(99) < 38) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func <= dir;
    req_if.block_upper <= hi;
    req_if.block_lower <= lo;
    do @(posedge clk); while (!req_if.ready);
    predict_block(dir, hi, lo, eh, el);
    sb.note_block(eh, el);
    if (dir) decs++; else encs++;
  endtask

  // Wait until every expected result has arrived, then let the pipe drain.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_blocks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_block(1'($urandom_range(1)), rand64(), rand64());
  endtask

  // Receiver: random back-pressure, long hold-off on request.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.result_upper, rsp_if.result_lower);
      rsp_if.ready <= !sink_hold && (no_idle || $urandom_range(99) >= 38);
    end
  end

  // Watchdog.
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cfg_mode = aesbc_pkg::ModeKey128;
    for (int i = 0; i < 4; i++) cfg_key[i] = '0;
    rk_stale = 1'b1;
    no_idle = 1'b0;
    sink_hold = 1'b0;
    encs = 0;
    decs = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset key: all-zero 128-bit key, extremes of the block and both directions.
    send_block(1'b0, 64'h0, 64'h0);
    send_block(1'b1, 64'h0, 64'h0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, '1);
    drain();

    // FIPS-197 appendix C vectors for each key length.
    load_key(aesbc_pkg::ModeKey128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    drain();
    load_key(aesbc_pkg::ModeKey192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '0);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    drain();
    load_key(aesbc_pkg::ModeKey256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    drain();

    // Unused mode code acts as a 256-bit key; all-ones key.
    load_key(aesbc_pkg::ModeSpare, '1, '1, '1, '1);
    send_block(1'b0, '1, 64'h0);
    send_block(1'b1, 64'h0, '1);
    drain();

    // Random phases: each writes a fresh key and mode, then random blocks.
    for (int ph = 0; ph < 8; ph++) begin
      load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
      if (ph == 2) no_idle = 1'b1;
      if (ph == 3) no_idle = 1'b0;
      if (ph == 4) begin
        // Hold off the receiver while the sender keeps offering blocks.
        fork
          begin
            sink_hold = 1'b1;
            repeat (200) @(posedge clk);
            sink_hold = 1'b0;
          end
          random_blocks(10);
        join
        random_blocks(30);
      end else begin
        random_blocks(45);
      end
      // Sender pauses until every result is in, then a single register
      // write marks the schedule stale without changing the whole key.
      drain();
      reg_write(aesbc_pkg::RegKey1, rand64());
      random_blocks(5);
      drain();
    end

    $display("covered %0d encrypt and %0d decrypt blocks over 128/192/256-bit keys",
             encs, decs);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
